@@ rtl/bet_pkg.sv @@
// Shared constants and codes for the block-exponent table lookup.
package bet_pkg;

	// Table geometry
	localparam int MAX_RANGE_BINS = 256;
	localparam int BIN_W          = $clog2(MAX_RANGE_BINS);
	localparam int LOW_W          = 64;
	localparam int HIGH_W         = 48;
	localparam int ENTRY_W        = LOW_W + HIGH_W;

	// Entry layout: base exponent, eight thresholds, growth count on top
	localparam int BASE_W      = 4;
	localparam int THRESH_W    = 13;
	localparam int THRESH_LSB  = BASE_W;
	localparam int NUM_THRESH  = 8;
	localparam int GROWTH_W    = 4;
	localparam int GROWTH_LSB  = ENTRY_W - GROWTH_W;
	localparam logic [GROWTH_W-1:0] GROWTH_LIMIT = GROWTH_W'(NUM_THRESH);

	// Item fields
	localparam int PULSE_W = 13;
	localparam int EXP_W   = 5;

	// Request kinds
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Configuration registers
	localparam int BINS_CFG_W   = 9;
	localparam int PULSES_CFG_W = 14;
	localparam int CFG_DATA_W   = 14;
	localparam int CFG_IDX_W    = 1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_BINS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSES     = 1'd1;
	localparam logic [BINS_CFG_W-1:0]   RANGE_BINS_RST = 9'd256;
	localparam logic [PULSES_CFG_W-1:0] PULSES_RST     = 14'd8192;

endpackage

@@ rtl/bet_if.sv @@
// Valid/ready channel interfaces for requests and responses.
interface bet_req_if;
	logic                              valid;
	logic                              ready;
	logic                              mode;
	logic [bet_pkg::BIN_W-1:0]         bin_index;
	logic [bet_pkg::LOW_W-1:0]         entry_low;
	logic [bet_pkg::HIGH_W-1:0]        entry_high;
	logic [bet_pkg::PULSE_W-1:0]       query_pulse;

	modport source (output valid, mode, bin_index, entry_low, entry_high, query_pulse,
		input ready);
	modport sink (input valid, mode, bin_index, entry_low, entry_high, query_pulse,
		output ready);
endinterface

interface bet_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [bet_pkg::EXP_W-1:0]   exponent;
	logic                        in_range;

	modport source (output valid, exponent, in_range, input ready);
	modport sink (input valid, exponent, in_range, output ready);
endinterface

@@ rtl/bet_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bet_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/bet_calc.sv @@
// Exponent calculation from one table entry and a pulse index.
module bet_calc (
	input  logic [bet_pkg::ENTRY_W-1:0]  entry,
	input  logic [bet_pkg::PULSE_W-1:0]  pulse,
	input  logic                         in_range,
	output logic [bet_pkg::EXP_W-1:0]    exponent
);

	logic [bet_pkg::GROWTH_W-1:0] growth;
	logic [bet_pkg::GROWTH_W-1:0] growth_clamped;
	logic [bet_pkg::GROWTH_W-1:0] steps;
	logic [bet_pkg::BASE_W-1:0]   base;
	logic [bet_pkg::NUM_THRESH-1:0] at_or_below;
	logic                         counting;

	// Each threshold compared against the pulse in parallel
	always_comb begin
		for (int n = 0; n < bet_pkg::NUM_THRESH; n++) begin
			at_or_below[n] = entry[bet_pkg::THRESH_LSB + n*bet_pkg::THRESH_W +: bet_pkg::THRESH_W]
				<= pulse;
		end
	end

	// Growth count clamped to the number of stored thresholds
	assign growth = entry[bet_pkg::GROWTH_LSB +: bet_pkg::GROWTH_W];
	assign growth_clamped = (growth > bet_pkg::GROWTH_LIMIT) ? bet_pkg::GROWTH_LIMIT : growth;
	assign base = entry[bet_pkg::BASE_W-1:0];

	// Count leading passed thresholds, stop at first miss or at growth count
	always_comb begin
		steps    = '0;
		counting = 1'b1;
		for (int n = 0; n < bet_pkg::NUM_THRESH; n++) begin
			if (counting && (bet_pkg::GROWTH_W'(n) < growth_clamped) && at_or_below[n]) begin
				steps = steps + bet_pkg::GROWTH_W'(1);
			end else begin
				counting = 1'b0;
			end
		end
	end

	assign exponent = in_range
		? (bet_pkg::EXP_W'(base) + bet_pkg::EXP_W'(steps))
		: '0;

endmodule

@@ rtl/block_exponent_table_lookup.sv @@
// Top level of the block-exponent table lookup.
// One request per cycle while rsp.ready allows: a write (mode 0) stores a 112-bit entry
// for a range bin and gives no response; a query (mode 1) gives one response, via the
// stage 1 table read and the stage 2 response register, holding the base exponent plus
// the count of leading thresholds at or below the pulse (growth count clamped to 8), or 0
// with in_range clear if the pulse or bin is outside the configured pulse and bin counts.
// Writes to bins outside the bin count are dropped. Throughput is one request per cycle
// while rsp.ready allows: each request needs at most one table access, and the response
// register refills in the cycle it drains; a query may follow a write of the same bin in
// the next cycle. Querying a bin that was never written returns an undefined exponent.
module block_exponent_table_lookup (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bet_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bet_pkg::CFG_DATA_W-1:0]    cfg_data,
	bet_req_if.sink                           req,
	bet_rsp_if.source                         rsp
);

	logic [bet_pkg::BINS_CFG_W-1:0]   bins_in_use_q;
	logic [bet_pkg::PULSES_CFG_W-1:0] pulses_q;

	logic                        accept;
	logic                        bin_ok;
	logic                        pulse_ok;
	logic                        ram_we;
	logic                        ram_re;
	logic [bet_pkg::ENTRY_W-1:0] entry_rd;

	logic                        valid_s1;
	logic [bet_pkg::PULSE_W-1:0] pulse_s1;
	logic                        in_range_s1;
	logic [bet_pkg::EXP_W-1:0]   exponent_calc;

	logic                        valid_s2;
	logic [bet_pkg::EXP_W-1:0]   exponent_s2;
	logic                        in_range_s2;
	logic                        s2_take;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_in_use_q <= bet_pkg::RANGE_BINS_RST;
			pulses_q      <= bet_pkg::PULSES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bet_pkg::REG_RANGE_BINS: bins_in_use_q <= cfg_data[bet_pkg::BINS_CFG_W-1:0];
				bet_pkg::REG_PULSES:     pulses_q      <= cfg_data[bet_pkg::PULSES_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: stage 1 moves on whenever the output register can take it
	assign s2_take   = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || s2_take;
	assign accept    = req.valid && req.ready;

	// Range checks on the incoming request
	assign bin_ok = ({1'b0, req.bin_index} < bins_in_use_q)
		&& ({1'b0, req.bin_index} < bet_pkg::BINS_CFG_W'(bet_pkg::MAX_RANGE_BINS));
	assign pulse_ok = {1'b0, req.query_pulse} < pulses_q;

	assign ram_we = accept && (req.mode == bet_pkg::MODE_WRITE) && bin_ok;
	assign ram_re = accept && (req.mode == bet_pkg::MODE_QUERY);

	// Entry table
	bet_ram #(
		.WIDTH (bet_pkg::ENTRY_W),
		.DEPTH (bet_pkg::MAX_RANGE_BINS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (req.bin_index),
		.wdata ({req.entry_high, req.entry_low}),
		.re    (ram_re),
		.raddr (req.bin_index),
		.rdata (entry_rd)
	);

	// Stage 1: query control alongside the table read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			pulse_s1    <= req.query_pulse;
			in_range_s1 <= pulse_ok && bin_ok;
		end
	end

	// Threshold compare and step count
	bet_calc u_calc (
		.entry    (entry_rd),
		.pulse    (pulse_s1),
		.in_range (in_range_s1),
		.exponent (exponent_calc)
	);

	// Stage 2: response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_take) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_take && valid_s1) begin
			exponent_s2 <= exponent_calc;
			in_range_s2 <= in_range_s1;
		end
	end

	assign rsp.valid    = valid_s2;
	assign rsp.exponent = exponent_s2;
	assign rsp.in_range = in_range_s2;

	// Out-of-range responses carry a zero exponent
	a_zero_when_out: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.in_range) |-> (rsp.exponent == '0))
		else $error("nonzero exponent on out-of-range response");

	// Exponent never exceeds base maximum plus eight steps
	a_exp_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.exponent <= bet_pkg::EXP_W'(23)))
		else $error("exponent above 23");

	// An accepted query is held in stage 1 the next cycle
	a_query_enters: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |=> valid_s1)
		else $error("accepted query lost");

	// A blocked stage 1 item stays put
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s2_take) |=> (valid_s1 && $stable(pulse_s1)))
		else $error("stage 1 item dropped while stalled");

	// Writes never produce a response slot
	a_write_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.mode == bet_pkg::MODE_WRITE)) |=> !valid_s1)
		else $error("write request produced a response");

endmodule
